// ----- hw/rtl/dpt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpt_pkg: primality test constants
// Size band limits and small prime table for the primality test.
// ----------------------------------------------------------------------------
package dpt_pkg;
  localparam int unsigned NUMBER_WIDTH_DEF = 49;
  localparam logic [48:0] BAND_TWO   = 49'd1373653;
  localparam logic [48:0] BAND_THREE = 49'd25326001;
  localparam logic [48:0] BAND_FOUR  = 49'd25000000000;
  localparam logic [48:0] FOUR_LIAR  = 49'd3215031751;
  localparam logic [48:0] BAND_FIVE  = 49'd2152302898747;
  localparam logic [48:0] BAND_SIX   = 49'd3474749660383;
  localparam logic [48:0] BAND_SEVEN = 49'd341550071728321;

  function automatic logic [4:0] small_prime(input logic [2:0] k);
    case (k)
      3'd0: small_prime = 5'd2;
      3'd1: small_prime = 5'd3;
      3'd2: small_prime = 5'd5;
      3'd3: small_prime = 5'd7;
      3'd4: small_prime = 5'd11;
      3'd5: small_prime = 5'd13;
      3'd6: small_prime = 5'd17;
      default: small_prime = 5'd2;
    endcase
  endfunction
endpackage

// ----- hw/rtl/deterministic_primality_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deterministic_primality_test
// Deterministic strong-probable-prime test, bases 2..17 by size band.
// ----------------------------------------------------------------------------
// channel  | ports                        | handshake
// input    | number_to_test               | start & !busy
// result   | is_prime, out_of_range       | done strobe, one cycle
//
// Modular multiply is bit-serial: one shift/add/reduce per cycle, MSB of the multiplier first.
// Residues mod 2..17 are taken one input bit per cycle.
// One test runs a square-and-multiply exponentiation per base, up to seven
// bases; the bit-serial multiplier sets how long an item takes.
// Synchronous reset returns to idle. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module deterministic_primality_test
  import dpt_pkg::*;
#(
  parameter int unsigned NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [48:0] number_to_test,
  output logic        busy,
  output logic        done,
  output logic        is_prime,
  output logic        out_of_range
);
  localparam int unsigned W  = NUMBER_WIDTH;
  localparam int unsigned CW = $clog2(W + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RES, S_CHECK, S_BASE, S_EXP, S_MUL, S_SQR_END, S_POST, S_FIN
  } state_t;

  state_t           state;
  logic [W-1:0]     n, nsh, d, x, b, acc, mx, my;
  logic [CW-1:0]    bitc, twos, cnt;
  logic [4:0]       res [7];
  logic [2:0]       k, nbases;
  logic             sqr_phase;   // 0: x*=b pending, 1: b*=b
  logic             post;
  logic [W+1:0]     dbl, dsum;
  logic [W-1:0]     acc_next;
  logic [W-1:0]     nm1;

  assign nm1 = n - W'(1);

  always_comb begin
    dbl = {2'b0, acc} << 1;
    if (dbl >= {2'b0, n}) dbl = dbl - {2'b0, n};
    dsum = dbl;
    if (mx[W-1]) dsum = dbl + {2'b0, my};
    if (dsum >= {2'b0, n}) dsum = dsum - {2'b0, n};
    acc_next = dsum[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            busy <= 1'b1;
            n <= number_to_test[W-1:0];
            nsh <= number_to_test[W-1:0];
            for (int i = 0; i < 7; i++) res[i] <= 5'd0;
            bitc <= CW'(W);
            state <= S_RES;
          end
        end
        S_RES: begin
          // residues mod small primes, one bit per cycle
          for (int i = 0; i < 7; i++) begin
            logic [5:0] r;
            r = {res[i], nsh[W-1]};
            if (r >= {1'b0, small_prime(3'(i))}) r = r - {1'b0, small_prime(3'(i))};
            res[i] <= r[4:0];
          end
          nsh <= nsh << 1;
          bitc <= bitc - CW'(1);
          if (bitc == CW'(1)) state <= S_CHECK;
        end
        S_CHECK: begin
          is_prime <= 1'b0;
          out_of_range <= 1'b0;
          state <= S_FIN;
          if (49'(n) >= BAND_SEVEN) out_of_range <= 1'b1;
          else if (n < W'(2)) ;
          else if (n == W'(2) || n == W'(3) || n == W'(5) || n == W'(7) ||
                   n == W'(11) || n == W'(13) || n == W'(17)) is_prime <= 1'b1;
          else if (res[0] == 0 || res[1] == 0 || res[2] == 0 || res[3] == 0 ||
                   res[4] == 0 || res[5] == 0 || res[6] == 0) ;
          else if (49'(n) == FOUR_LIAR) ;
          else begin
            if (49'(n) < BAND_TWO) nbases <= 3'd2;
            else if (49'(n) < BAND_THREE) nbases <= 3'd3;
            else if (49'(n) < BAND_FOUR) nbases <= 3'd4;
            else if (49'(n) < BAND_FIVE) nbases <= 3'd5;
            else if (49'(n) < BAND_SIX) nbases <= 3'd6;
            else nbases <= 3'd7;
            k <= 3'd0;
            state <= S_BASE;
          end
        end
        S_BASE: begin
          // n > 17 and odd, so base < n
          b <= W'(small_prime(k));
          x <= W'(1);
          d <= nm1 >> 1;
          twos <= CW'(1);
          state <= S_POST;
          post <= 1'b0;
        end
        S_POST: begin
          if (!post) begin
            // strip remaining factors of two
            if (!d[0]) begin
              d <= d >> 1;
              twos <= twos + CW'(1);
            end else begin
              post <= 1'b1;
              sqr_phase <= 1'b0;
              state <= S_EXP;
            end
          end
        end
        S_EXP: begin
          if (d == '0) begin
            cnt <= CW'(1);
            state <= S_SQR_END;
          end else if (!sqr_phase && d[0]) begin
            mx <= x; my <= b; acc <= '0; bitc <= CW'(W);
            state <= S_MUL;
          end else begin
            sqr_phase <= 1'b1;
            mx <= b; my <= b; acc <= '0; bitc <= CW'(W);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          acc <= acc_next;
          mx <= mx << 1;
          bitc <= bitc - CW'(1);
          if (bitc == CW'(1)) begin
            if (post && d != '0) begin
              if (!sqr_phase) begin
                x <= acc_next;
                sqr_phase <= 1'b1;
              end else begin
                b <= acc_next;
                d <= d >> 1;
                sqr_phase <= 1'b0;
              end
              state <= S_EXP;
            end else begin
              x <= acc_next;
              cnt <= cnt + CW'(1);
              state <= S_SQR_END;
            end
          end
        end
        S_SQR_END: begin
          if (cnt == CW'(1) && (x == W'(1) || x == nm1)) begin
            state <= S_FIN;
            is_prime <= 1'b1;
            if (k + 3'd1 < nbases) begin
              k <= k + 3'd1;
              state <= S_BASE;
            end
          end else if (cnt != CW'(1) && x == nm1) begin
            state <= S_FIN;
            is_prime <= 1'b1;
            if (k + 3'd1 < nbases) begin
              k <= k + 3'd1;
              state <= S_BASE;
            end
          end else if ((cnt != CW'(1) && x == W'(1)) || cnt >= twos) begin
            is_prime <= 1'b0;
            state <= S_FIN;
          end else begin
            mx <= x; my <= x; acc <= '0; bitc <= CW'(W);
            state <= S_MUL;
          end
        end
        S_FIN: begin
          done <= 1'b1;
          busy <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: deterministic_primality_test testbench
// Drives numbers through the start/busy command port and checks each done
// beat against the table's typed verdict or an in-bench strong-probable-prime
// predictor. Directed boundary cases run first, then random numbers come
// mostly from low bands, the rest from upper bands and out-of-range values.
// ----------------------------------------------------------------------------
module tb_top;
  import dpt_pkg::*;

  localparam int unsigned IDLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned N_RANDOM = 75;

  typedef struct packed {
    logic prime;
    logic oor;
  } verdict_t;

  typedef struct {
    logic [48:0] num;
    bit          typed;
    verdict_t    want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic [48:0] number_to_test;
  logic        busy;
  logic        done;
  logic        is_prime;
  logic        out_of_range;

  verdict_t    verdict_q[$];
  int unsigned idle_cycles;
  bit          failed;
  bit          no_gaps;

  deterministic_primality_test DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .number_to_test (number_to_test),
    .busy           (busy),
    .done           (done),
    .is_prime       (is_prime),
    .out_of_range   (out_of_range)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [48:0] mod_mul(logic [48:0] x, logic [48:0] y, logic [48:0] m);
    logic [97:0] prod;
    prod = {49'd0, x} * {49'd0, y};
    return 49'(prod % {49'd0, m});
  endfunction

  function automatic bit passes_sprp(logic [48:0] a, logic [48:0] n);
    logic [48:0] d;
    logic [48:0] x;
    logic [48:0] b;
    int unsigned twos;
    d = n - 1;
    x = 1;
    b = a % n;
    twos = 0;
    while (d[0] == 1'b0) begin
      d = d >> 1;
      twos++;
    end
    while (d != 0) begin
      if (d[0]) x = mod_mul(x, b, n);
      b = mod_mul(b, b, n);
      d = d >> 1;
    end
    if (x == 1 || x == n - 1) return 1'b1;
    for (int unsigned i = 1; i < twos; i++) begin
      x = mod_mul(x, x, n);
      if (x == n - 1) return 1'b1;
      if (x == 1) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic verdict_t primality_of(logic [48:0] raw);
    logic [48:0] n;
    logic [48:0] bases [7];
    int unsigned nbases;
    verdict_t v;
    bases = '{49'd2, 49'd3, 49'd5, 49'd7, 49'd11, 49'd13, 49'd17};
    n = raw;
    v = '0;
    if (n >= BAND_SEVEN) begin
      v.oor = 1'b1;
      return v;
    end
    if (n < 2) return v;
    foreach (bases[k]) if (n == bases[k]) begin
      v.prime = 1'b1;
      return v;
    end
    foreach (bases[k]) if (n % bases[k] == 0) return v;
    if (n < BAND_TWO) nbases = 2;
    else if (n < BAND_THREE) nbases = 3;
    else if (n < BAND_FOUR) nbases = 4;
    else if (n < BAND_FIVE) nbases = 5;
    else if (n < BAND_SIX) nbases = 6;
    else nbases = 7;
    if (n == FOUR_LIAR) return v;
    v.prime = 1'b1;
    for (int unsigned k = 0; k < nbases && v.prime; k++) v.prime = passes_sprp(bases[k], n);
    return v;
  endfunction

  function automatic logic [48:0] rand_below(logic [48:0] lim);
    logic [63:0] r;
    r = {$urandom, $urandom};
    return 49'(r % {15'd0, lim});
  endfunction

  function automatic logic [48:0] random_number();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return rand_below(BAND_TWO);
    if (pick < 68) return BAND_TWO + rand_below(BAND_THREE - BAND_TWO);
    if (pick < 78) return BAND_THREE + rand_below(BAND_FOUR - BAND_THREE);
    if (pick < 84) return BAND_FOUR + rand_below(BAND_SEVEN - BAND_FOUR);
    return 49'({$urandom, $urandom});
  endfunction

  // one beat: hold start until accepted, optional gap afterwards
  task automatic send_number(logic [48:0] num, bit typed, verdict_t want);
    start <= 1'b1;
    number_to_test <= num;
    do @(posedge clk); while (busy);
    verdict_q.push_back(typed ? want : primality_of(num));
    if (!no_gaps && $urandom_range(99) < 13) begin
      start <= 1'b0;
      number_to_test <= 49'({$urandom, $urandom});
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: result with none expected: is_prime=%0b out_of_range=%0b",
                 $time, is_prime, out_of_range);
        failed = 1'b1;
      end else begin
        verdict_t want;
        want = verdict_q.pop_front();
        if (is_prime !== want.prime) begin
          $display("%0t: is_prime expected %0b actual %0b", $time, want.prime, is_prime);
          failed = 1'b1;
        end
        if (out_of_range !== want.oor) begin
          $display("%0t: out_of_range expected %0b actual %0b", $time, want.oor,
                   out_of_range);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[deterministic_primality_test] ERROR");
      $finish;
    end
  end

  initial begin
    stim_row_t table_rows[$];
    table_rows = '{
      '{49'd0,                 1'b1, '{1'b0, 1'b0}},
      '{49'd1,                 1'b1, '{1'b0, 1'b0}},
      '{49'd2,                 1'b1, '{1'b1, 1'b0}},
      '{49'd3,                 1'b1, '{1'b1, 1'b0}},
      '{49'd5,                 1'b1, '{1'b1, 1'b0}},
      '{49'd7,                 1'b1, '{1'b1, 1'b0}},
      '{49'd11,                1'b1, '{1'b1, 1'b0}},
      '{49'd13,                1'b1, '{1'b1, 1'b0}},
      '{49'd17,                1'b1, '{1'b1, 1'b0}},
      '{49'd4,                 1'b1, '{1'b0, 1'b0}},
      '{49'd289,               1'b1, '{1'b0, 1'b0}},
      '{49'd19,                1'b1, '{1'b1, 1'b0}},
      '{49'd361,               1'b1, '{1'b0, 1'b0}},
      '{49'd2047,              1'b0, '0},
      '{49'd1373653,           1'b0, '0},
      '{49'd25326001,          1'b0, '0},
      '{49'd3215031751,        1'b1, '{1'b0, 1'b0}},
      '{49'd2152302898747,     1'b0, '0},
      '{49'd3474749660383,     1'b0, '0},
      '{49'd24999999967,       1'b0, '0},
      '{49'd341550071728320,   1'b1, '{1'b0, 1'b0}},
      '{49'd341550071728319,   1'b0, '0},
      '{49'd341550071728321,   1'b1, '{1'b0, 1'b1}},
      '{49'h1_FFFF_FFFF_FFFF,  1'b1, '{1'b0, 1'b1}},
      '{49'h1_0000_0000_0000,  1'b1, '{1'b0, 1'b0}}
    };
    failed = 1'b0;
    no_gaps = 1'b0;
    start = 1'b0;
    number_to_test = '0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (table_rows[i]) send_number(table_rows[i].num, table_rows[i].typed,
                                        table_rows[i].want);
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      no_gaps = (i >= 30 && i < 55);
      send_number(random_number(), 1'b0, '0);
    end
    start <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("[deterministic_primality_test] OK");
    end else begin
      $display("[deterministic_primality_test] ERROR");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hw/rtl/dpt_pkg.sv
hw/rtl/deterministic_primality_test.sv
dv/tb_top.sv
